@@ rtl/sb32_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sb32_pkg
// shared types, constants and the letter decode for the sorted base32 decoder
// ----------------------------------------------------------------------------
package sb32_pkg;

  localparam int MAX_TEXT_CHARS  = 96;
  localparam int GROUP_CHARS     = 8;
  localparam int LETTER_W        = 5;
  localparam int ACC_W           = LETTER_W * (GROUP_CHARS - 1);
  localparam int GROUP_W         = LETTER_W * GROUP_CHARS;
  localparam int BYTES_PER_GROUP = GROUP_W / 8;
  localparam int POS_W           = $clog2(GROUP_CHARS);
  localparam int CNT_W           = $clog2(MAX_TEXT_CHARS + 2);
  localparam int BYTE_IDX_W      = $clog2(BYTES_PER_GROUP);

  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] DIGIT_FIRST  = 8'h33;  // '3'
  localparam logic [7:0] DIGIT_LAST   = 8'h39;  // '9'
  localparam logic [7:0] UPPER_FIRST  = 8'h41;  // 'A'
  localparam logic [7:0] UPPER_LAST   = 8'h59;  // 'Y'
  localparam logic [7:0] UPPER_OFFSET = 8'd7;   // 'A' follows the seven digits
  localparam logic [LETTER_W-1:0] BAD_LETTER_VALUE = '1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LEN    = 2'd1,
    ST_BAD_LETTER = 2'd2
  } status_t;

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic [GROUP_W-1:0] data;
    logic               has_data;
    logic               last;
    status_t            status;
  } work_t;

  typedef struct packed {
    logic                bad;
    logic [LETTER_W-1:0] value;
  } letter_t;

  function automatic letter_t letter_decode(input logic [7:0] c);
    letter_t r;
    logic [7:0] d;
    d = 8'd0;
    r.bad   = 1'b0;
    r.value = BAD_LETTER_VALUE;
    if (c >= DIGIT_FIRST && c <= DIGIT_LAST) begin
      d = c - DIGIT_FIRST;
      r.value = d[LETTER_W-1:0];
    end else if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
      d = c - UPPER_FIRST + UPPER_OFFSET;
      r.value = d[LETTER_W-1:0];
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ rtl/sb32_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sb32_front
// letter decode, group accumulation, length count and final status
// ----------------------------------------------------------------------------
module sb32_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_text_char,
  input  logic            in_last_char,
  output logic            work_push,
  output sb32_pkg::work_t work
);
  import sb32_pkg::*;

  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_TEXT_CHARS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TEXT_CHARS);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(GROUP_CHARS);
  localparam logic [POS_W-1:0] POS_END = POS_W'(GROUP_CHARS - 1);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             bad_r, bad_nxt;

  letter_t          letter;
  logic [CNT_W-1:0] cnt_inc;
  logic             bad_now;
  logic             group_done;
  status_t          status;

  always_comb begin
    letter     = letter_decode(in_text_char);
    bad_now    = bad_r | letter.bad;
    cnt_inc    = (cnt_r < CNT_SAT) ? cnt_r + 1'b1 : cnt_r;
    group_done = (pos_r == POS_END);

    priority if (cnt_inc < CNT_MIN || cnt_inc > CNT_MAX
                 || cnt_inc[POS_W-1:0] != '0) begin
      status = ST_BAD_LEN;
    end else if (bad_now) begin
      status = ST_BAD_LETTER;
    end else begin
      status = ST_OK;
    end

    work.data     = {acc_r, letter.value};
    work.has_data = group_done;
    work.last     = in_last_char;
    work.status   = in_last_char ? status : ST_OK;
    work_push     = accept & (group_done | in_last_char);

    acc_nxt = acc_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    bad_nxt = bad_r;
    if (accept) begin
      if (in_last_char) begin
        acc_nxt = '0;
        pos_nxt = '0;
        cnt_nxt = '0;
        bad_nxt = 1'b0;
      end else begin
        acc_nxt = group_done ? '0 : {acc_r[ACC_W-LETTER_W-1:0], letter.value};
        pos_nxt = pos_r + 1'b1;
        cnt_nxt = cnt_inc;
        bad_nxt = bad_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pos_r <= '0;
      cnt_r <= '0;
      bad_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
      bad_r <= bad_nxt;
    end
  end

endmodule

@@ rtl/sb32_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sb32_fifo
// short work queue between the front and the back
// ----------------------------------------------------------------------------
module sb32_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sb32_pkg::work_t push_data,
  input  logic            pop,
  output sb32_pkg::work_t head,
  output logic            full,
  output logic            empty
);
  import sb32_pkg::*;

  work_t                 entries_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  always_comb begin
    full       = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
    empty      = (count_r == '0);
    do_push    = push & ~full;
    do_pop     = pop & ~empty;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
    head = entries_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/sb32_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sb32_back
// walks the head work entry out as bytes, most significant first
// ----------------------------------------------------------------------------
module sb32_back (
  input  logic            clk,
  input  logic            rst_n,
  input  sb32_pkg::work_t head,
  input  logic            head_empty,
  input  logic            out_pop,
  output logic            head_pop,
  output logic            out_empty,
  output logic [7:0]      out_data_byte,
  output logic            out_byte_valid,
  output logic            out_last_result,
  output logic [1:0]      out_status
);
  import sb32_pkg::*;

  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = BYTE_IDX_W'(BYTES_PER_GROUP - 1);

  logic [BYTE_IDX_W-1:0] idx_r, idx_nxt;
  logic                  final_beat;
  logic                  beat;

  always_comb begin
    unique case (idx_r)
      3'd0:    out_data_byte = head.data[39:32];
      3'd1:    out_data_byte = head.data[31:24];
      3'd2:    out_data_byte = head.data[23:16];
      3'd3:    out_data_byte = head.data[15:8];
      3'd4:    out_data_byte = head.data[7:0];
      default: out_data_byte = 8'd0;
    endcase
    if (!head.has_data) begin
      out_data_byte = 8'd0;
    end

    final_beat      = ~head.has_data | (idx_r == LAST_BYTE);
    out_empty       = head_empty;
    out_byte_valid  = head.has_data;
    out_last_result = head.last & final_beat;
    out_status      = final_beat ? head.status : ST_OK;

    beat     = out_pop & ~head_empty;
    head_pop = beat & final_beat;
    idx_nxt  = idx_r;
    if (beat) begin
      idx_nxt = final_beat ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ rtl/sorted_base32_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_base32_decoder_core
// base32 decoder over the sorted alphabet '3'..'9','A'..'Y'
// ----------------------------------------------------------------------------
// usage
//   input side is a queue write port: drive in_text_char / in_last_char and
//   raise in_push; the beat is taken when in_full is low. one character per
//   cycle is taken for as long as the work queue has room
//   every eighth character finishes a 40-bit group which comes out as five
//   byte beats, most significant first; a character flagged last closes the
//   string and its final result carries last_result and the status (bad
//   length checked first, then bad letter). a last character that does not
//   finish a group gives one status-only beat with byte_valid low
//   result side is a queue read port: a result sits on the out_ ports while
//   out_empty is low and is taken with out_pop
//   results are registered in the work queue between decode and the walker
//   throughput: one character per cycle in while in_full is low, one byte
//   per cycle out while out_pop is high; the four-entry work queue sets how
//   far the input can run ahead of a stalled reader before in_full rises
//   reset: synchronous, clears the string state, the queue and the walker
// ----------------------------------------------------------------------------
module sorted_base32_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_text_char,
  input  logic       in_last_char,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_data_byte,
  output logic       out_byte_valid,
  output logic       out_last_result,
  output logic [1:0] out_status
);
  import sb32_pkg::*;

  logic  accept;
  logic  work_push;
  work_t work;
  work_t head;
  logic  head_pop;
  logic  head_empty;

  // an input beat is taken only when the queue has room for its work
  assign accept = in_push & ~in_full;

  sb32_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_text_char (in_text_char),
    .in_last_char (in_last_char),
    .work_push    (work_push),
    .work         (work)
  );

  sb32_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (work_push),
    .push_data (work),
    .pop       (head_pop),
    .head      (head),
    .full      (in_full),
    .empty     (head_empty)
  );

  // byte walker: the queue head stays until its last byte beat goes out
  sb32_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_empty      (head_empty),
    .out_pop         (out_pop),
    .head_pop        (head_pop),
    .out_empty       (out_empty),
    .out_data_byte   (out_data_byte),
    .out_byte_valid  (out_byte_valid),
    .out_last_result (out_last_result),
    .out_status      (out_status)
  );

  // a status-only beat is always the closing one
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_byte_valid) |-> out_last_result)
    else $error("status-only beat without last_result");

  // status is zero except on the closing beat
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != 2'd0) |-> out_last_result)
    else $error("status on a non-final beat");

  // a full queue always has a result to offer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("queue full while result side empty");

  // reset leaves nothing to read
  assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("results visible after reset");

endmodule
